>>> rtl/button_click_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// button click classifier assertion macros
// concurrent assertion forms used by bcc_core
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define BCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define BCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// types, codes and defaults shared by the button click classifier
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int MAX_CLICKS_DEF = 10;
  localparam int MIN_TRIPLE     = 3;

  localparam int CLICK_W    = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIN_INVERTED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 4'd3;

  localparam logic [31:0] DEBOUNCE_RST     = 32'd10000;
  localparam logic [31:0] LONG_PRESS_RST   = 32'd700000;
  localparam logic [31:0] CLICK_WINDOW_RST = 32'd350000;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_TRIPLE = 2'd3
  } event_t;

  typedef struct packed {
    logic        pin_inverted;
    logic [31:0] debounce_time;
    logic [31:0] long_press_time;
    logic [31:0] click_window_time;
  } cfg_t;

  typedef struct packed {
    event_t               event_res;
    logic                 pressed;
    logic [CLICK_W-1:0]   clicks;
  } res_t;

endpackage

>>> rtl/bcc_channels.sv
// ----------------------------------------------------------------------------
// bcc channels
// valid/ready interfaces for samples, results and register writes
// ----------------------------------------------------------------------------
interface bcc_sample_if
  import bcc_pkg::*;
#(
  parameter int TimeBits = TIME_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                raw_level;
  logic [TimeBits-1:0] now_time;

  modport source (output valid, raw_level, now_time, input ready);
  modport sink   (input valid, raw_level, now_time, output ready);
endinterface

interface bcc_result_if
  import bcc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [1:0]         event_res;
  logic               pressed;
  logic [CLICK_W-1:0] clicks;

  modport source (output valid, event_res, pressed, clicks, input ready);
  modport sink   (input valid, event_res, pressed, clicks, output ready);
endinterface

interface bcc_cfg_if
  import bcc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// button_click_classifier_top
// debounced button press classifier: short, long and triple press events
// ----------------------------------------------------------------------------
// samples: one beat per pin sample, raw_level with a microsecond now_time.
// results: one beat per sample, event_res (none, short, long, triple), the
//   debounced pressed state and the click count after that sample.
// cfg: register writes by index (pin_inverted, debounce_time, long_press_time,
//   click_window_time); always ready, unknown indexes ignored. Write only
//   while no sample is in flight.
// A result beat is registered in the result register, or in the skid entry
// when the receiver stalls. Throughput is one sample per cycle while samples
// ready is high, set by the single compare and update pass between the
// sample port and the result register. A stalled receiver fills the result
// register and then a skid entry; samples ready drops only while both are
// full and rises again once the receiver takes a beat.
// Reset (rst, synchronous) loads the default registers, sets the button to
// released with all timestamps and the click count at zero, and empties the
// result buffer.
// ----------------------------------------------------------------------------
module button_click_classifier_top
  import bcc_pkg::*;
#(
  parameter int TimeBits  = TIME_BITS_DEF,
  parameter int MaxClicks = MAX_CLICKS_DEF
)(
  input  logic         clk,
  input  logic         rst,
  bcc_sample_if.sink   samples,
  bcc_result_if.source results,
  bcc_cfg_if.sink      cfg
);

  cfg_t cfg_regs;

  bcc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_regs (cfg_regs)
  );

  bcc_core #(
    .TimeBits  (TimeBits),
    .MaxClicks (MaxClicks)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .samples  (samples),
    .results  (results)
  );

endmodule

>>> rtl/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// configuration register file, always ready, unknown indexes ignored
// ----------------------------------------------------------------------------
module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bcc_cfg_if.sink     cfg,
  output cfg_t        cfg_regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pin_inverted      <= 1'b1;
      cfg_regs.debounce_time     <= DEBOUNCE_RST;
      cfg_regs.long_press_time   <= LONG_PRESS_RST;
      cfg_regs.click_window_time <= CLICK_WINDOW_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PIN_INVERTED: cfg_regs.pin_inverted      <= cfg.data[0];
        REG_DEBOUNCE:     cfg_regs.debounce_time     <= cfg.data;
        REG_LONG_PRESS:   cfg_regs.long_press_time   <= cfg.data;
        REG_CLICK_WINDOW: cfg_regs.click_window_time <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// debounce, long-press and multi-click state with a two-entry result buffer
// ----------------------------------------------------------------------------
module bcc_core
  import bcc_pkg::*;
#(
  parameter int TimeBits  = TIME_BITS_DEF,
  parameter int MaxClicks = MAX_CLICKS_DEF
)(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg_regs,
  bcc_sample_if.sink  samples,
  bcc_result_if.source results
);

  `include "button_click_classifier_top_defines.svh"

  localparam logic [CLICK_W-1:0] MaxCnt    = CLICK_W'(MaxClicks);
  localparam logic [CLICK_W-1:0] TripleCnt = CLICK_W'(MIN_TRIPLE);
  localparam logic [CLICK_W-1:0] OneCnt    = CLICK_W'(1);

  logic                stable_pressed, stable_pressed_next;
  logic                long_done, long_done_next;
  logic [TimeBits-1:0] last_change_time, last_change_time_next;
  logic [TimeBits-1:0] press_start_time, press_start_time_next;
  logic [TimeBits-1:0] last_release_time, last_release_time_next;
  logic [CLICK_W-1:0]  click_count, click_count_next;

  logic                want;
  logic                deb_ok, long_ok, win_ok;
  event_t              ev;
  res_t                res_new;

  res_t                out_data, skid_data;
  logic                out_valid, skid_valid;
  logic                accept;

  assign samples.ready = !skid_valid;
  assign accept        = samples.valid && samples.ready;

  assign want    = cfg_regs.pin_inverted ? !samples.raw_level : samples.raw_level;
  // modular elapsed times against zero-extended thresholds
  assign deb_ok  = (samples.now_time - last_change_time) >=
                   TimeBits'(cfg_regs.debounce_time);
  assign long_ok = (samples.now_time - press_start_time) >=
                   TimeBits'(cfg_regs.long_press_time);
  assign win_ok  = (samples.now_time - last_release_time) >=
                   TimeBits'(cfg_regs.click_window_time);

  always_comb begin
    stable_pressed_next    = stable_pressed;
    long_done_next         = long_done;
    last_change_time_next  = last_change_time;
    press_start_time_next  = press_start_time;
    last_release_time_next = last_release_time;
    click_count_next       = click_count;
    ev                     = EV_NONE;
    if (want != stable_pressed) begin
      if (deb_ok) begin
        stable_pressed_next   = want;
        last_change_time_next = samples.now_time;
        if (want) begin
          press_start_time_next = samples.now_time;
          long_done_next        = 1'b0;
        end else begin
          last_release_time_next = samples.now_time;
          if (!long_done) begin
            if (click_count < MaxCnt) begin
              click_count_next = click_count + OneCnt;
            end
          end else begin
            long_done_next   = 1'b0;
            click_count_next = '0;
          end
        end
      end
    end else if (stable_pressed) begin
      if (!long_done && long_ok) begin
        long_done_next   = 1'b1;
        click_count_next = '0;
        ev               = EV_LONG;
      end
    end else if ((click_count != '0) && win_ok) begin
      // two clicks fall through as no event
      if (click_count == OneCnt) begin
        ev = EV_SHORT;
      end else if (click_count >= TripleCnt) begin
        ev = EV_TRIPLE;
      end
      click_count_next = '0;
    end
    res_new.event_res = ev;
    res_new.pressed   = stable_pressed_next;
    res_new.clicks    = click_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_pressed    <= 1'b0;
      long_done         <= 1'b0;
      last_change_time  <= '0;
      press_start_time  <= '0;
      last_release_time <= '0;
      click_count       <= '0;
    end else if (accept) begin
      stable_pressed    <= stable_pressed_next;
      long_done         <= long_done_next;
      last_change_time  <= last_change_time_next;
      press_start_time  <= press_start_time_next;
      last_release_time <= last_release_time_next;
      click_count       <= click_count_next;
    end
  end

  // output register plus skid entry for a stalled receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || results.ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        out_data  <= res_new;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept) begin
      skid_data  <= res_new;
      skid_valid <= 1'b1;
    end
  end

  assign results.valid     = out_valid;
  assign results.event_res = out_data.event_res;
  assign results.pressed   = out_data.pressed;
  assign results.clicks    = out_data.clicks;

  `BCC_ASSERT_NOW(a_clicks_bound, clk, rst, out_valid, out_data.clicks <= MaxCnt,
    "click count above limit")
  `BCC_ASSERT_NOW(a_long_held, clk, rst, out_valid && out_data.event_res == EV_LONG,
    out_data.pressed && out_data.clicks == '0, "long event without held press")
  `BCC_ASSERT_NOW(a_class_released, clk, rst,
    out_valid && (out_data.event_res == EV_SHORT || out_data.event_res == EV_TRIPLE),
    !out_data.pressed && out_data.clicks == '0, "click event while pressed")
  `BCC_ASSERT_NOW(a_skid_order, clk, rst, skid_valid, out_valid,
    "skid entry without output entry")
  `BCC_ASSERT_NEXT(a_accept_shows, clk, rst, accept, out_valid,
    "accepted sample left no result")

endmodule
